[design/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
// Holds the beat payload structs, the stored slot layout and the control enums.
// No dependencies.
package spq_pkg;

    // Fixed field widths of the queue entries and the result beat.
    localparam int PRIO_BITS = 4;
    localparam int TAG_BITS  = 16;
    localparam int OCC_BITS  = 5;

    // Item operation code.
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_SERVE  = 1'b1
    } kind_t;

    // Result status code.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SERVE = 2'd1,
        ST_SCAN  = 2'd2,
        ST_PLACE = 2'd3
    } state_t;

    // Input beat.
    typedef struct packed {
        kind_t                 kind;
        logic [PRIO_BITS-1:0]  priority_req;
        logic [TAG_BITS-1:0]   entry_tag;
    } item_t;

    // Result beat.
    typedef struct packed {
        status_t               status;
        logic [PRIO_BITS-1:0]  served_priority;
        logic [TAG_BITS-1:0]   served_tag;
        logic [OCC_BITS-1:0]   occupancy;
    } result_t;

    // One stored queue slot.
    typedef struct packed {
        logic [PRIO_BITS-1:0]  prio;
        logic [TAG_BITS-1:0]   tag;
    } slot_t;

endpackage

[design/stable_priority_queue.sv]
// Stable priority queue: entries are held sorted by priority (lower is more urgent) in a
// circular RAM, with equal priorities kept in arrival order. Every input beat gives exactly
// one result beat carrying the status and the occupancy after the item. A serve reads the
// head slot and reports it from the serve state. An insert into a non-empty queue walks
// the RAM from the tail toward the head, one slot per cycle through the single read and
// write port, moving each entry of larger priority up by one. An insert into an empty
// queue, a refused insert and a serve on an empty queue finish straight from idle. The
// next item is taken once the sequencer is back in idle and the result register is free
// or being drained. No clearing pass is needed after reset.
// Depends on spq_pkg and spq_ram.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

    // Circular slot address: base plus offset, folded once into the depth.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    slot_t               hold_reg, hold_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    logic                move_up;
    logic                done;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    wr_off;
    slot_t               wr_slot;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    rd_off;
    logic [$bits(slot_t)-1:0] ram_rd_data;
    slot_t               rd_slot;

    assign item_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || result_ready);
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign is_full      = (count_reg == DEPTH_CNT);
    assign is_empty     = (count_reg == '0);
    assign rd_slot      = slot_t'(ram_rd_data);

    // Shared compare unit: the slot just read yields its place to the new entry.
    assign move_up      = (rd_slot.prio > hold_reg.prio);

    // Slot store.
    spq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wrap_add(head_reg, wr_off)),
        .wr_data (wr_slot),
        .rd_en   (ram_rd_en),
        .rd_addr (wrap_add(head_reg, rd_off)),
        .rd_data (ram_rd_data)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == KIND_SERVE)
                    begin
                        if (!is_empty)
                        begin
                            state_next = ST_SERVE;
                        end
                    end
                    else if (!is_full && !is_empty)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SERVE:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (!move_up)
                begin
                    state_next = ST_IDLE;
                end
                else if (scan_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control: RAM ports, pointers and the result register.
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        done           = 1'b0;
        ram_wr_en      = 1'b0;
        wr_off         = '0;
        wr_slot        = hold_reg;
        ram_rd_en      = 1'b0;
        rd_off         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hold_next.prio = item.priority_req;
                    hold_next.tag  = item.entry_tag;
                    if (item.kind == KIND_SERVE)
                    begin
                        if (is_empty)
                        begin
                            done     = 1'b1;
                            out_next = '{STATUS_EMPTY, '0, '0, OCC_BITS'(count_reg)};
                        end
                        else
                        begin
                            // Fetch the head slot.
                            ram_rd_en = 1'b1;
                            rd_off    = '0;
                        end
                    end
                    else if (is_full)
                    begin
                        done     = 1'b1;
                        out_next = '{STATUS_FULL, '0, '0, OCC_BITS'(count_reg)};
                    end
                    else if (is_empty)
                    begin
                        // First entry goes straight to the head slot.
                        ram_wr_en    = 1'b1;
                        wr_off       = '0;
                        wr_slot.prio = item.priority_req;
                        wr_slot.tag  = item.entry_tag;
                        count_next   = count_reg + 1'b1;
                        done         = 1'b1;
                        out_next     = '{STATUS_OK, '0, '0, OCC_BITS'(count_next)};
                    end
                    else
                    begin
                        // Start the walk at the tail entry.
                        ram_rd_en = 1'b1;
                        rd_off    = IDX_W'(count_reg - 1'b1);
                        scan_next = IDX_W'(count_reg - 1'b1);
                    end
                end
            end
            ST_SERVE:
            begin
                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                done       = 1'b1;
                out_next   = '{STATUS_OK, rd_slot.prio, rd_slot.tag, OCC_BITS'(count_next)};
            end
            ST_SCAN:
            begin
                ram_wr_en = 1'b1;
                wr_off    = scan_reg + 1'b1;
                if (move_up)
                begin
                    // Shift this entry one slot toward the tail and read the next one.
                    wr_slot = rd_slot;
                    if (scan_reg != '0)
                    begin
                        ram_rd_en = 1'b1;
                        rd_off    = scan_reg - 1'b1;
                        scan_next = scan_reg - 1'b1;
                    end
                end
                else
                begin
                    // New entry lands just behind the last entry of lower or equal priority.
                    wr_slot    = hold_reg;
                    count_next = count_reg + 1'b1;
                    done       = 1'b1;
                    out_next   = '{STATUS_OK, '0, '0, OCC_BITS'(count_next)};
                end
            end
            ST_PLACE:
            begin
                ram_wr_en  = 1'b1;
                wr_off     = '0;
                wr_slot    = hold_reg;
                count_next = count_reg + 1'b1;
                done       = 1'b1;
                out_next   = '{STATUS_OK, '0, '0, OCC_BITS'(count_next)};
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        // A finished item always finds the result register free or draining.
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count above queue depth");

    // A walk only runs while there is room for the new entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_PLACE) |-> !is_full)
        else $error("insert walk on a full queue");

    // A serve of a held entry removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SERVE) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("serve did not remove one entry");

    // Refused or empty results carry no served entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != STATUS_OK)
            |-> (out_reg.served_priority == '0 && out_reg.served_tag == '0))
        else $error("error result carries a served entry");

endmodule

[design/spq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the slot store of the stable priority queue. No dependencies.
module spq_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[verif/stable_priority_queue_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for stable_priority_queue: directed and random insert/serve beats.
// Depends on spq_pkg and stable_priority_queue; a shadow of the sorted queue predicts results.
module stable_priority_queue_tb
    import spq_pkg::*;
;

    localparam int QUEUE_DEPTH    = 16;
    localparam int RANDOM_ITEMS   = 1628;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;

    // Shadow copy of the queue contents and the list of results still owed by the block.
    class spq_shadow #(int DEPTH = 16);
        logic [PRIO_BITS-1:0] held_prio [DEPTH];
        logic [TAG_BITS-1:0]  held_tag [DEPTH];
        int                   held_count;
        result_t              owed_results [$];
        int                   fail_count;

        function new();
            held_count = 0;
            fail_count = 0;
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        // Apply one accepted input beat to the shadow and queue up its result.
        function void apply_item(item_t it);
            result_t want;
            int      pos;
            int      i;
            want = '0;
            want.status = STATUS_OK;
            if (it.kind == KIND_INSERT)
            begin
                if (held_count >= DEPTH)
                    want.status = STATUS_FULL;
                else
                begin
                    // The new entry goes behind every entry of equal or smaller priority.
                    pos = 0;
                    while (pos < held_count && held_prio[pos] <= it.priority_req)
                        pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_prio[i] = held_prio[i-1];
                        held_tag[i]  = held_tag[i-1];
                    end
                    held_prio[pos] = it.priority_req;
                    held_tag[pos]  = it.entry_tag;
                    held_count++;
                end
            end
            else if (held_count == 0)
                want.status = STATUS_EMPTY;
            else
            begin
                want.served_priority = held_prio[0];
                want.served_tag      = held_tag[0];
                for (i = 1; i < held_count; i++)
                begin
                    held_prio[i-1] = held_prio[i];
                    held_tag[i-1]  = held_tag[i];
                end
                held_count--;
            end
            want.occupancy = OCC_BITS'(held_count);
            owed_results.push_back(want);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        // Compare one accepted result beat against the oldest owed result.
        function void compare_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result beat with no item pending: status %0d occupancy %0d",
                       got.status, got.occupancy);
                fail_count++;
                return;
            end
            want = owed_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("served_priority", want.served_priority, got.served_priority);
            check_field("served_tag", want.served_tag, got.served_tag);
            check_field("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    spq_shadow #(QUEUE_DEPTH) shadow;
    int source_gap_pct;
    int sink_stall_pct;
    int hold_request;

    stable_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic item_t make_item(kind_t k, logic [PRIO_BITS-1:0] p,
                                        logic [TAG_BITS-1:0] t);
        item_t it;
        it.kind         = k;
        it.priority_req = p;
        it.entry_tag    = t;
        return it;
    endfunction

    // Offer one input beat, with an occasional idle gap first, and hold it until accepted.
    task automatic send_item(input item_t it);
        if ($urandom_range(0, 99) < source_gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        shadow.apply_item(it);
    endtask

    // Result side: check accepted beats, stall at random, and honor long hold-off requests.
    initial
    begin : result_sink
        int hold_left;
        hold_left    = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                shadow.compare_result(result);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("stable_priority_queue test failed");
                $finish;
            end
        end
    end

    // Main stimulus: reset, directed beats, then random segments.
    initial
    begin : stimulus
        logic [PRIO_BITS-1:0] fill_prio [16];
        int                   n;
        int                   insert_pct;
        int                   prio_max;
        kind_t                k;

        shadow         = new();
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        source_gap_pct = 10;
        sink_stall_pct = 10;
        hold_request   = 0;
        fill_prio      = '{4'd5, 4'd5, 4'd0, 4'd15, 4'd15, 4'd0, 4'd7, 4'd3,
                           4'd3, 4'd9, 4'd15, 4'd0, 4'd8, 4'd1, 4'd14, 4'd7};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Serve on an empty queue.
        send_item(make_item(KIND_SERVE, '1, '1));
        // Fill to the brim with repeated and extreme priorities and tags.
        for (n = 0; n < QUEUE_DEPTH; n++)
            send_item(make_item(KIND_INSERT, fill_prio[n],
                                (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF :
                                16'(n * 16'h1111 + 16'h0100)));
        // Insert into a full queue is refused.
        send_item(make_item(KIND_INSERT, 4'd0, 16'h5A5A));
        // A few serves take equal-priority heads in arrival order.
        for (n = 0; n < 4; n++)
            send_item(make_item(KIND_SERVE, '0, '0));

        // Random segments sweep the occupancy between empty and full.
        insert_pct = 50;
        prio_max   = 15;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    2: insert_pct = 80;
                    default: insert_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: prio_max = 1;
                    1: prio_max = 3;
                    default: prio_max = 15;
                endcase
            end
            // Long receiver hold-off so the block backs up into its input.
            if (n == 300 || n == 1200)
                hold_request = LONG_HOLD;
            // A stretch with no idling on either side.
            if (n == 700)
            begin
                source_gap_pct = 0;
                sink_stall_pct = 0;
            end
            if (n == 1000)
            begin
                source_gap_pct = 10;
                sink_stall_pct = 10;
            end
            k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_SERVE;
            send_item(make_item(k, PRIO_BITS'($urandom_range(0, prio_max)),
                                TAG_BITS'($urandom)));
        end
        item_valid <= 1'b0;

        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (QUEUE_DEPTH + 4) @(posedge clk);

        if (shadow.fail_count == 0)
            $display("stable_priority_queue test passed");
        else
            $display("stable_priority_queue test failed");
        $finish;
    end

endmodule
